// ----- src/bmsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap mark-sweep allocator package
// Sizes, request and status codes, controller states and the command bundle
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package bmsa_pkg;

    // Geometry of the slot store.
    localparam int NUM_PAGES      = 4;
    localparam int SLOTS_PER_PAGE = 64;
    localparam int PAGE_W         = 2;
    localparam int SLOT_W         = 6;
    localparam int CNT_W          = 7;
    localparam int CFG_W          = 3;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;

    // Request kinds carried on the slave-side user field.
    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_MARK  = 2'd2,
        REQ_SWEEP = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNALLOC = 2'd2,
        ST_MARKED  = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_fsm;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// ----- src/bmsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bitmap mark-sweep allocator controller
// Sequences one request at a time: capture, execute, then hold the result in
// the output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module bmsa_ctrl
    import bmsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    input  logic i_m_ready,
    output logic o_s_ready,
    output logic o_m_valid,
    output t_cmd o_cmd
);

    t_fsm r_state, n_state;
    logic r_out_valid, n_out_valid;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands. A new request is taken only when the output
    // register is empty or is being emptied in the same cycle.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_ready;
        o_s_ready   = 1'b0;
        o_cmd       = '0;
        case (r_state)
            FSM_IDLE: begin
                o_s_ready = !r_out_valid || i_m_ready;
                if (i_s_valid && o_s_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = FSM_IDLE;
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_out_valid;

endmodule

// ----- src/bmsa_datapath.sv -----
// ----------------------------------------------------------------------------
// Bitmap mark-sweep allocator datapath
// Holds the allocated, mark and companion maps, the page-count register, the
// captured request and the result register, and performs one request when
// the controller commands it.
// ----------------------------------------------------------------------------
module bmsa_datapath
    import bmsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_req                  i_req,
    input  logic [PAGE_W-1:0]     i_page,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic                  i_comp,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output logic [OUT_DATA_W-1:0] o_data
);

    // Population count of one page word.
    function automatic logic [CNT_W-1:0] count_ones(input logic [SLOTS_PER_PAGE-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < SLOTS_PER_PAGE; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS_PER_PAGE-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS_PER_PAGE - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [SLOTS_PER_PAGE-1:0] r_alloc [NUM_PAGES];
    logic [SLOTS_PER_PAGE-1:0] r_mark  [NUM_PAGES];
    logic [SLOTS_PER_PAGE-1:0] r_comp  [NUM_PAGES];
    logic [CFG_W-1:0]          r_cfg;

    t_req              r_req;
    logic [PAGE_W-1:0] r_page;
    logic [SLOT_W-1:0] r_slot;
    logic              r_own;

    t_status                   r_status;
    logic [PAGE_W-1:0]         r_page_out;
    logic [SLOT_W-1:0]         r_slot_out;
    logic [CNT_W-1:0]          r_cnt;
    logic [SLOTS_PER_PAGE-1:0] r_rel;

    logic [CFG_W-1:0]          pages_in_use;
    logic [NUM_PAGES-1:0]      page_en;
    logic [NUM_PAGES-1:0]      page_hit;
    logic [SLOT_W-1:0]         low_free [NUM_PAGES];
    logic [PAGE_W-1:0]         alloc_page;
    logic [SLOT_W-1:0]         alloc_slot;
    logic                      alloc_found;
    logic [SLOTS_PER_PAGE-1:0] alloc_bit;
    logic                      sel_alloc;
    logic                      sel_mark;
    logic                      mark_ok;
    t_status                   mark_status;
    logic [SLOTS_PER_PAGE-1:0] freed;
    logic [SLOTS_PER_PAGE-1:0] slot_bit;

    // Enabled pages, with the count saturated to the pages built.
    assign pages_in_use = (r_cfg > CFG_W'(NUM_PAGES)) ? CFG_W'(NUM_PAGES) : r_cfg;

    // Per-page free search; the highest enabled page with a free slot wins.
    always_comb begin
        alloc_page = '0;
        for (int p = 0; p < NUM_PAGES; p++) begin
            page_en[p]  = CFG_W'(p) < pages_in_use;
            page_hit[p] = page_en[p] && (~r_alloc[p] != '0);
            low_free[p] = lowest_set(~r_alloc[p]);
            if (page_hit[p]) begin
                alloc_page = PAGE_W'(p);
            end
        end
        alloc_found = |page_hit;
        alloc_slot  = low_free[alloc_page];
        alloc_bit   = SLOTS_PER_PAGE'(1) << alloc_slot;
    end

    // Mark and sweep look at the requested page.
    assign slot_bit  = SLOTS_PER_PAGE'(1) << r_slot;
    assign sel_alloc = r_alloc[r_page][r_slot];
    assign sel_mark  = r_mark[r_page][r_slot];
    assign mark_ok   = page_en[r_page] && sel_alloc && !sel_mark;
    assign freed     = page_en[r_page] ? (r_alloc[r_page] & ~r_mark[r_page]) : '0;

    always_comb begin
        if (!page_en[r_page] || !sel_alloc) begin
            mark_status = ST_UNALLOC;
        end else if (sel_mark) begin
            mark_status = ST_MARKED;
        end else begin
            mark_status = ST_OK;
        end
    end

    // Request capture and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_page <= i_page;
            r_slot <= i_slot;
            r_own  <= i_comp;
        end
        if (i_cmd.exec) begin
            r_status   <= ST_OK;
            r_page_out <= '0;
            r_slot_out <= '0;
            r_cnt      <= '0;
            r_rel      <= '0;
            case (r_req)
                REQ_ALLOC: begin
                    if (alloc_found) begin
                        r_page_out <= alloc_page;
                        r_slot_out <= alloc_slot;
                    end else begin
                        r_status <= ST_FULL;
                    end
                end
                REQ_MARK: begin
                    r_status <= mark_status;
                end
                REQ_SWEEP: begin
                    r_cnt <= count_ones(freed);
                    r_rel <= freed & r_comp[r_page];
                end
                default: begin
                end
            endcase
        end
    end

    // Page maps and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(1);
            for (int p = 0; p < NUM_PAGES; p++) begin
                r_alloc[p] <= '0;
                r_mark[p]  <= '0;
                r_comp[p]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                case (r_req)
                    REQ_ALLOC: begin
                        if (alloc_found) begin
                            r_alloc[alloc_page] <= r_alloc[alloc_page] | alloc_bit;
                            if (r_own) begin
                                r_comp[alloc_page] <= r_comp[alloc_page] | alloc_bit;
                            end else begin
                                r_comp[alloc_page] <= r_comp[alloc_page] & ~alloc_bit;
                            end
                        end
                    end
                    REQ_CLEAR: begin
                        for (int p = 0; p < NUM_PAGES; p++) begin
                            r_mark[p] <= '0;
                        end
                    end
                    REQ_MARK: begin
                        if (mark_ok) begin
                            r_mark[r_page] <= r_mark[r_page] | slot_bit;
                        end
                    end
                    REQ_SWEEP: begin
                        r_alloc[r_page] <= r_alloc[r_page] & ~freed;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result packing, highest field first.
    assign o_data = {7'b0, r_rel, r_cnt, r_slot_out, r_page_out, r_status};

endmodule

// ----- src/bitmap_mark_sweep_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap mark-sweep allocator
// Slot allocator with per-page allocated, mark and companion bitmaps.
// ----------------------------------------------------------------------------
// Each request is handled in turn: the controller first captures the transfer,
// then the datapath searches the pages, updates the bitmaps and loads the
// result register; no new request is accepted while one is executing. The
// controller's capture and execute states sequence the combinational alloc
// search and sweep popcount. The next request may be accepted while a
// finished result still waits, provided the result is taken in that cycle.
// The user must write the page count through the configuration port only
// while the block is idle; the block itself does not enforce this. Values
// above the pages built saturate. No clearing pass follows reset.
module bitmap_mark_sweep_allocator
    import bmsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // page_sel, slot_sel, owns_companion, zero pad
    input  logic [1:0]            s_axis_tuser,  // req_type
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // status, page_out, slot_out, freed_count,
                                                 // release_mask, zero pad
    // Configuration.
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    t_cmd cmd;

    // Sequencing of transfers.
    bmsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    // Bitmaps and request execution.
    bmsa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (t_req'(s_axis_tuser)),
        .i_page      (s_axis_tdata[1:0]),
        .i_slot      (s_axis_tdata[7:2]),
        .i_comp      (s_axis_tdata[8]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_data      (m_axis_tdata)
    );

endmodule

// ----- src/bmsa_checker.sv -----
// ----------------------------------------------------------------------------
// Bitmap mark-sweep allocator checker
// Port-level assertions on transfer sequencing and result fields, bound to
// the top level.
// ----------------------------------------------------------------------------
module bmsa_checker
    import bmsa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // No request is taken while a result is stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request accepted while result stalled");

    // After an accepted request, the result valid first stays low while the request executes and then rises.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid ##1 m_axis_tvalid)
        else $error("result timing broken");

    // A sweep never frees more slots than a page holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:10] <= CNT_W'(SLOTS_PER_PAGE))
        else $error("freed count out of range");

    // A failed request reports no slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[9:2] == '0)
        else $error("slot reported with error status");

endmodule

bind bitmap_mark_sweep_allocator bmsa_checker u_bmsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
